>>> rtl/scsc_pkg.sv
// ----------------------------------------------------------------------------
// scsc_pkg
// shared types and constants for the segment / cube slab clipper
// ----------------------------------------------------------------------------
package scsc_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int WB         = COORD_BITS + 2;   // slab bounds, never wrap
    localparam int DW         = COORD_BITS + 1;   // divisor and delta width
    localparam int TW         = FRAC_BITS + 1;    // t in Q0.FRAC_BITS incl. 1.0
    localparam int PW         = DW + TW;
    localparam int NLANE      = 6;                // entry and exit per axis

    localparam logic [TW-1:0] T_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [TW-1:0] T_ZERO = '0;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic signed [COORD_BITS-1:0] center_z;
        logic        [COORD_BITS-2:0] half_size;
        logic signed [COORD_BITS-1:0] seg_start_x;
        logic signed [COORD_BITS-1:0] seg_start_y;
        logic signed [COORD_BITS-1:0] seg_start_z;
        logic signed [COORD_BITS-1:0] seg_end_x;
        logic signed [COORD_BITS-1:0] seg_end_y;
        logic signed [COORD_BITS-1:0] seg_end_z;
    } t_in_beat;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] entry_x;
        logic signed [COORD_BITS-1:0] entry_y;
        logic signed [COORD_BITS-1:0] entry_z;
        logic signed [COORD_BITS-1:0] exit_x;
        logic signed [COORD_BITS-1:0] exit_y;
        logic signed [COORD_BITS-1:0] exit_z;
    } t_out_beat;

    // one restoring division in flight
    typedef struct packed {
        logic [DW-1:0]        den;
        logic [DW:0]          rem;
        logic [FRAC_BITS-1:0] q;
        logic                 fix;
        logic [TW-1:0]        fix_val;
    } t_lane;

    // data that rides along with the divisions
    typedef struct packed {
        logic                         rej;
        logic [2:0][COORD_BITS-1:0]   s;
        logic [2:0][DW-1:0]           dv;
    } t_side;

endpackage

>>> rtl/scsc_setup.sv
// ----------------------------------------------------------------------------
// scsc_setup
// slab bounds, per-axis reject and divider operands, one register stage
// ----------------------------------------------------------------------------
module scsc_setup
    import scsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  t_in_beat                i_beat,
    output logic                    o_vld,
    output t_lane [NLANE-1:0]       o_lane,
    output t_side                   o_side
);

    logic              r_vld;
    t_lane [NLANE-1:0] r_lane, n_lane;
    t_side             r_side, n_side;

    logic [2:0][COORD_BITS-1:0] c_raw, s_raw, e_raw;
    logic signed [WB-1:0]       c, s, e, r, hi, lo;
    logic signed [WB-1:0]       num_st, num_et, den;
    logic                       use_st, use_et, asc;
    logic [WB-1:0]              tmp;

    function automatic logic signed [WB-1:0] sx(input logic [COORD_BITS-1:0] v);
        sx = {{(WB-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic t_lane lane_init(input logic u, input logic signed [WB-1:0] num,
                                        input logic signed [WB-1:0] dn,
                                        input logic [TW-1:0] dflt);
        t_lane l;
        l.den     = dn[DW-1:0];
        l.rem     = num[DW:0];
        l.q       = '0;
        l.fix     = 1'b0;
        l.fix_val = dflt;
        if (!u) begin
            l.fix = 1'b1;
        end else if (l.den == '0) begin
            l.fix     = 1'b1;
            l.fix_val = T_ZERO;
        end else if (l.rem >= {1'b0, l.den}) begin
            l.fix     = 1'b1;
            l.fix_val = T_ONE;
        end
        lane_init = l;
    endfunction

    always_comb begin
        c_raw = {i_beat.center_z, i_beat.center_y, i_beat.center_x};
        s_raw = {i_beat.seg_start_z, i_beat.seg_start_y, i_beat.seg_start_x};
        e_raw = {i_beat.seg_end_z, i_beat.seg_end_y, i_beat.seg_end_x};
        r     = $signed({{(WB-COORD_BITS+1){1'b0}}, i_beat.half_size});
        n_side.rej = 1'b0;
        n_lane     = '0;
        c = '0; s = '0; e = '0; hi = '0; lo = '0;
        num_st = '0; num_et = '0; den = '0; use_st = 1'b0; use_et = 1'b0;
        asc = 1'b0; tmp = '0;
        for (int a = 0; a < 3; a++) begin
            c   = sx(c_raw[a]);
            s   = sx(s_raw[a]);
            e   = sx(e_raw[a]);
            hi  = c + r;
            lo  = c - r;
            asc = s < e;
            if (asc) begin
                den    = e - s;
                if (s > hi || e < lo) n_side.rej = 1'b1;
                num_st = lo - s;
                use_st = lo > s;
                num_et = hi - s;
                use_et = e > hi;
            end else begin
                den    = s - e;
                if (e > hi || s < lo) n_side.rej = 1'b1;
                num_st = s - hi;
                use_st = s > hi;
                num_et = s - lo;
                use_et = e < lo;
            end
            n_lane[2*a]   = lane_init(use_st, num_st, den, T_ZERO);
            n_lane[2*a+1] = lane_init(use_et, num_et, den, T_ONE);
            n_side.s[a]   = s_raw[a];
            tmp           = e - s;
            n_side.dv[a]  = tmp[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_lane = r_lane;
    assign o_side = r_side;

endmodule

>>> rtl/scsc_div.sv
// ----------------------------------------------------------------------------
// scsc_div
// pipelined restoring divider, one quotient bit per stage for all six lanes
// ----------------------------------------------------------------------------
module scsc_div
    import scsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  t_lane [NLANE-1:0]       i_lane,
    input  t_side                   i_side,
    output logic                    o_vld,
    output logic [NLANE-1:0][TW-1:0] o_t,
    output t_side                   o_side
);

    function automatic t_lane div_step(input t_lane l);
        t_lane       o;
        logic [DW:0] sh;
        o  = l;
        sh = {l.rem[DW-1:0], 1'b0};
        if (sh >= {1'b0, l.den}) begin
            o.rem = sh - {1'b0, l.den};
            o.q   = {l.q[FRAC_BITS-2:0], 1'b1};
        end else begin
            o.rem = sh;
            o.q   = {l.q[FRAC_BITS-2:0], 1'b0};
        end
        div_step = o;
    endfunction

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
        logic              r_vld;
        t_lane [NLANE-1:0] r_lane, n_lane;
        t_side             r_side;
        logic              p_vld;
        t_lane [NLANE-1:0] p_lane;
        t_side             p_side;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_lane = i_lane;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = g_stage[k-1].r_vld;
            assign p_lane = g_stage[k-1].r_lane;
            assign p_side = g_stage[k-1].r_side;
        end

        always_comb begin
            for (int j = 0; j < NLANE; j++) begin
                n_lane[j] = div_step(p_lane[j]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_lane <= n_lane;
                r_side <= p_side;
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NLANE; j++) begin
            o_t[j] = g_stage[FRAC_BITS-1].r_lane[j].fix
                   ? g_stage[FRAC_BITS-1].r_lane[j].fix_val
                   : {1'b0, g_stage[FRAC_BITS-1].r_lane[j].q};
        end
    end

    assign o_vld  = g_stage[FRAC_BITS-1].r_vld;
    assign o_side = g_stage[FRAC_BITS-1].r_side;

endmodule

>>> rtl/scsc_lerp.sv
// ----------------------------------------------------------------------------
// scsc_lerp
// interval narrowing, then start + floor(dv * t) for entry and exit points
// ----------------------------------------------------------------------------
module scsc_lerp
    import scsc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [NLANE-1:0][TW-1:0] i_t,
    input  t_side                    i_side,
    output logic                     o_vld,
    output t_out_beat                o_beat
);

    // stage a: interval
    logic          r_a_vld, r_a_hit;
    logic [TW-1:0] r_a_tin, r_a_tout;
    t_side         r_a_side;
    logic [TW-1:0] n_tin, n_tout;

    // stage b: products
    logic                        r_b_vld, r_b_hit;
    logic [NLANE-1:0][PW-1:0]    r_b_p, n_p;
    logic [NLANE-1:0]            r_b_neg, n_neg;
    logic [2:0][COORD_BITS-1:0]  r_b_s;
    logic [DW-1:0]               mag;

    // stage c: output register
    logic                        r_c_vld;
    t_out_beat                   r_c_beat, n_beat;
    logic [NLANE-1:0][COORD_BITS-1:0] pt;
    logic [COORD_BITS-1:0]       q;
    logic                        adj;

    always_comb begin
        n_tin  = T_ZERO;
        n_tout = T_ONE;
        for (int a = 0; a < 3; a++) begin
            if (i_t[2*a] > n_tin)    n_tin  = i_t[2*a];
            if (i_t[2*a+1] < n_tout) n_tout = i_t[2*a+1];
        end
    end

    always_comb begin
        mag = '0;
        for (int j = 0; j < NLANE; j++) begin
            n_neg[j] = r_a_side.dv[j/2][DW-1];
            mag      = n_neg[j] ? (~r_a_side.dv[j/2] + 1'b1) : r_a_side.dv[j/2];
            n_p[j]   = PW'(mag) * PW'(j[0] ? r_a_tout : r_a_tin);
        end
    end

    always_comb begin
        q   = '0;
        adj = 1'b0;
        for (int j = 0; j < NLANE; j++) begin
            q   = r_b_p[j][FRAC_BITS +: COORD_BITS];
            adj = |r_b_p[j][FRAC_BITS-1:0];
            if (r_b_neg[j]) begin
                pt[j] = r_b_s[j/2] - q - COORD_BITS'(adj);
            end else begin
                pt[j] = r_b_s[j/2] + q;
            end
            if (!r_b_hit) pt[j] = '0;
        end
        n_beat.hit     = r_b_hit;
        n_beat.entry_x = pt[0];
        n_beat.exit_x  = pt[1];
        n_beat.entry_y = pt[2];
        n_beat.exit_y  = pt[3];
        n_beat.entry_z = pt[4];
        n_beat.exit_z  = pt[5];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_tin  <= n_tin;
            r_a_tout <= n_tout;
            r_a_hit  <= !i_side.rej && (n_tout >= n_tin);
            r_a_side <= i_side;
            r_b_p    <= n_p;
            r_b_neg  <= n_neg;
            r_b_s    <= r_a_side.s;
            r_b_hit  <= r_a_hit;
            r_c_beat <= n_beat;
        end
    end

    assign o_vld  = r_c_vld;
    assign o_beat = r_c_beat;

endmodule

>>> rtl/segment_cube_slab_clip.sv
// ----------------------------------------------------------------------------
// segment_cube_slab_clip
// segment versus axis-aligned cube clipping, fully pipelined
// ----------------------------------------------------------------------------
// one input beat carries a cube (center, half size) and a segment (start,
// end) in signed Q16.16; one output beat carries hit and the clipped entry
// and exit points, all zero on a miss. both channels use valid / stall.
// from input beat to output beat the registers are: input register,
// operand setup, 16 restoring divider stages (one quotient bit each, six
// divisions side by side), interval narrowing, multiply, add / output reg.
// one beat per cycle unless stalled; every stage holds a valid bit.
// when the receiver stalls while an output beat is waiting, the whole
// pipeline freezes and o_stall rises; nothing is dropped or repeated.
// reset clears all valid bits; the block takes beats in the next cycle.
// ----------------------------------------------------------------------------
module segment_cube_slab_clip
    import scsc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_in,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_out
);

    logic                     en;
    logic                     r_in_vld;
    t_in_beat                 r_in;
    logic                     su_vld, dv_vld;
    t_lane [NLANE-1:0]        su_lane;
    t_side                    su_side, dv_side;
    logic [NLANE-1:0][TW-1:0] dv_t;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_in;
        end
    end

    scsc_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_in_vld),
        .i_beat  (r_in),
        .o_vld   (su_vld),
        .o_lane  (su_lane),
        .o_side  (su_side)
    );

    scsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (su_vld),
        .i_lane  (su_lane),
        .i_side  (su_side),
        .o_vld   (dv_vld),
        .o_t     (dv_t),
        .o_side  (dv_side)
    );

    scsc_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (dv_vld),
        .i_t     (dv_t),
        .i_side  (dv_side),
        .o_vld   (o_valid),
        .o_beat  (o_out)
    );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench for segment_cube_slab_clip
// drives cube / segment beats with random idling on both channels and
// checks every output beat against a fixed-point slab clipping predictor
// ----------------------------------------------------------------------------
module testbench;
    import scsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_in;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_out;

    t_out_beat clip_queue[$];
    int        n_err;
    int        n_sent;
    int        n_hits;
    int        n_checked;
    bit        quiet;

    segment_cube_slab_clip u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_in   (i_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out  (o_out)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // t = num / den in Q0.16, truncated
    function automatic longint unsigned t_ratio(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = num;
        if (den == 0) return 0;
        if (rem >= den) return 64'd1 << FRAC_BITS;
        for (int k = 0; k < FRAC_BITS; k++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q | 1;
            end
        end
        return q;
    endfunction

    function automatic logic [COORD_BITS-1:0] lerp(longint s, longint dv, longint unsigned t);
        longint unsigned m;
        longint unsigned lo;
        longint unsigned q;
        m  = (dv < 0) ? longint'(-dv) : dv;
        lo = (m & 16'hffff) * t;
        q  = (m >> FRAC_BITS) * t + (lo >> FRAC_BITS);
        if (dv < 0) begin
            if ((lo & 16'hffff) != 0) q = q + 1;
            return COORD_BITS'(s - longint'(q));
        end
        return COORD_BITS'(s + longint'(q));
    endfunction

    function automatic t_out_beat clip_segment(t_in_beat b);
        t_out_beat       r;
        longint          c[3];
        longint          s[3];
        longint          e[3];
        longint          hs;
        longint          hi;
        longint          lo;
        longint unsigned t_lo;
        longint unsigned t_hi;
        longint unsigned st;
        longint unsigned et;
        c = '{longint'(b.center_x), longint'(b.center_y), longint'(b.center_z)};
        s = '{longint'(b.seg_start_x), longint'(b.seg_start_y), longint'(b.seg_start_z)};
        e = '{longint'(b.seg_end_x), longint'(b.seg_end_y), longint'(b.seg_end_z)};
        hs   = longint'({1'b0, b.half_size});
        t_lo = 0;
        t_hi = 64'd1 << FRAC_BITS;
        r    = '0;
        for (int a = 0; a < 3; a++) begin
            hi = c[a] + hs;
            lo = c[a] - hs;
            if (s[a] < e[a]) begin
                if (s[a] > hi || e[a] < lo) return r;
                st = (lo - s[a] > 0) ? t_ratio(lo - s[a], e[a] - s[a]) : 0;
                et = (e[a] > hi) ? t_ratio(hi - s[a], e[a] - s[a]) : 64'd1 << FRAC_BITS;
            end else begin
                if (e[a] > hi || s[a] < lo) return r;
                st = (hi - s[a] < 0) ? t_ratio(s[a] - hi, s[a] - e[a]) : 0;
                et = (e[a] < lo) ? t_ratio(s[a] - lo, s[a] - e[a]) : 64'd1 << FRAC_BITS;
            end
            if (st > t_lo) t_lo = st;
            if (et < t_hi) t_hi = et;
            if (t_hi < t_lo) return r;
        end
        r.hit     = 1'b1;
        r.entry_x = lerp(s[0], e[0] - s[0], t_lo);
        r.entry_y = lerp(s[1], e[1] - s[1], t_lo);
        r.entry_z = lerp(s[2], e[2] - s[2], t_lo);
        r.exit_x  = lerp(s[0], e[0] - s[0], t_hi);
        r.exit_y  = lerp(s[1], e[1] - s[1], t_hi);
        r.exit_z  = lerp(s[2], e[2] - s[2], t_hi);
        return r;
    endfunction

    // valid stays high between beats unless an idle burst drops it
    task automatic send_beat(t_in_beat b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= b;
        clip_queue.push_back(clip_segment(b));
        n_sent++;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // receiver stall bursts
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 6) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat x;
        if (i_rst_n && o_valid && !i_stall) begin
            if (clip_queue.size() == 0) begin
                $error("output beat with nothing expected");
                n_err++;
            end else begin
                x = clip_queue.pop_front();
                n_checked++;
                if (x.hit) n_hits++;
                if (o_out.hit !== x.hit)
                    $error("hit exp %0d got %0d", x.hit, o_out.hit);
                if (o_out.entry_x !== x.entry_x)
                    $error("entry_x exp %0d got %0d", x.entry_x, o_out.entry_x);
                if (o_out.entry_y !== x.entry_y)
                    $error("entry_y exp %0d got %0d", x.entry_y, o_out.entry_y);
                if (o_out.entry_z !== x.entry_z)
                    $error("entry_z exp %0d got %0d", x.entry_z, o_out.entry_z);
                if (o_out.exit_x !== x.exit_x)
                    $error("exit_x exp %0d got %0d", x.exit_x, o_out.exit_x);
                if (o_out.exit_y !== x.exit_y)
                    $error("exit_y exp %0d got %0d", x.exit_y, o_out.exit_y);
                if (o_out.exit_z !== x.exit_z)
                    $error("exit_z exp %0d got %0d", x.exit_z, o_out.exit_z);
                if (o_out !== x) n_err++;
            end
        end
    end

    function automatic t_in_beat make_beat(int cx, int cy, int cz, int hs,
                                           int sx, int sy, int sz,
                                           int ex, int ey, int ez);
        t_in_beat b;
        b.center_x    = cx;
        b.center_y    = cy;
        b.center_z    = cz;
        b.half_size   = hs[30:0];
        b.seg_start_x = sx;
        b.seg_start_y = sy;
        b.seg_start_z = sz;
        b.seg_end_x   = ex;
        b.seg_end_y   = ey;
        b.seg_end_z   = ez;
        return b;
    endfunction

    localparam int ONE  = 32'h0001_0000;
    localparam int MAXC = 32'h7fff_ffff;
    localparam int MINC = 32'h8000_0000;

    task automatic test_directed();
        // straight through the cube, both directions
        send_beat(make_beat(0, 0, 0, ONE, -2*ONE, 0, 0, 2*ONE, 0, 0));
        send_beat(make_beat(0, 0, 0, ONE, 2*ONE, ONE/2, 0, -2*ONE, -ONE/2, ONE/3));
        // miss on each axis
        send_beat(make_beat(0, 0, 0, ONE, 3*ONE, 0, 0, 5*ONE, 0, 0));
        send_beat(make_beat(0, 0, 0, ONE, 0, -5*ONE, 0, 0, -3*ONE, 0));
        send_beat(make_beat(0, 0, 0, ONE, 0, 0, 4*ONE, ONE, 0, 9*ONE));
        // touching a face, and an edge graze
        send_beat(make_beat(0, 0, 0, ONE, ONE, -ONE, 0, ONE, ONE, 0));
        send_beat(make_beat(0, 0, 0, ONE, 0, 2*ONE, 0, 2*ONE, 0, 0));
        // degenerate segment inside and outside
        send_beat(make_beat(0, 0, 0, ONE, 5, 7, -9, 5, 7, -9));
        send_beat(make_beat(0, 0, 0, ONE, 5*ONE, 7, -9, 5*ONE, 7, -9));
        // interval empties across axes
        send_beat(make_beat(0, 0, 0, ONE, -3*ONE, ONE/2, 0, ONE/2, 3*ONE, 0));
        // extremes of the coordinate range
        send_beat(make_beat(MAXC, MINC, 0, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC));
        send_beat(make_beat(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC));
        send_beat(make_beat(MAXC, MAXC, MAXC, 0, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
        send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(-1, -1, -1, MAXC, -1, 0, 1, 1, 0, -1));
        send_beat(make_beat(0, 0, 0, 0, -1, 0, 0, 1, 0, 0));
    endtask

    function automatic int near_coord(int c, int span);
        return c + $signed($urandom_range(0, 2*span)) - span;
    endfunction

    task automatic test_random(int count);
        t_in_beat     b;
        logic [319:0] raw;
        int           span;
        int           hs;
        for (int n = 0; n < count; n++) begin
            if (n >= count - 200) quiet = 1;
            if ($urandom_range(0, 9) < 2) begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom};
                b   = raw[$bits(t_in_beat)-1:0];
            end else begin
                // segments around the cube so hits, grazes and misses all occur
                span = 1 << $urandom_range(4, 28);
                hs   = $urandom_range(0, span);
                b.center_x    = $urandom;
                b.center_y    = $urandom;
                b.center_z    = $urandom;
                b.half_size   = hs[30:0];
                b.seg_start_x = near_coord(b.center_x, span);
                b.seg_start_y = near_coord(b.center_y, span);
                b.seg_start_z = near_coord(b.center_z, span);
                b.seg_end_x   = near_coord(b.center_x, span);
                b.seg_end_y   = near_coord(b.center_y, span);
                b.seg_end_z   = near_coord(b.center_z, span);
                if ($urandom_range(0, 7) == 0) b.seg_end_x = b.seg_start_x;
                if ($urandom_range(0, 7) == 0) b.seg_end_y = b.seg_start_y;
            end
            send_beat(b);
        end
    endtask

    initial begin
        int wait_cycles;
        n_err = 0; n_sent = 0; n_hits = 0; n_checked = 0; quiet = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_in    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1750);
        i_valid <= 1'b0;
        wait_cycles = 0;
        while (clip_queue.size() != 0 && wait_cycles < 10000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (clip_queue.size() != 0) begin
            $error("%0d beats never came out", clip_queue.size());
            n_err++;
        end
        $display("sent %0d segment / cube beats, checked %0d, %0d of them hits",
                 n_sent, n_checked, n_hits);
        if (n_err == 0)
            $display("[segment_cube_slab_clip] OK");
        else
            $display("[segment_cube_slab_clip] ERROR");
        $finish;
    end

    initial begin
        #2ms;
        $display("[segment_cube_slab_clip] ERROR");
        $finish;
    end

endmodule
